FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/fbb_pkg.sv
// ----------------------------------------------------------------------------
// fbb_pkg
// types and constants shared by the free block bitmap modules
// ----------------------------------------------------------------------------
`default_nettype none

package fbb_pkg;

  // widths fixed by the item and register fields
  localparam int IDX_W   = 10;  // bit index
  localparam int CNT_W   = 11;  // bit count, free count
  localparam int CNT_MAX = (2 ** CNT_W) - 1;

  // map words
  localparam int WORD_BITS = 32;
  localparam int POS_W     = 5;  // bit position inside a word
  localparam int WIDX_W    = CNT_W - POS_W + 1;  // word index, holds word count too
  localparam int ZCNT_W    = POS_W + 1;  // zero count of one word

  // action codes
  localparam logic [1:0] ACT_USE  = 2'd0;
  localparam logic [1:0] ACT_FREE = 2'd1;
  localparam logic [1:0] ACT_TEST = 2'd2;

  // per-word evaluation result
  typedef struct packed {
    logic              has_zero;
    logic [POS_W-1:0]  zero_pos;
    logic [ZCNT_W-1:0] zero_cnt;
  } word_eval_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fbb_map_ram.sv
// ----------------------------------------------------------------------------
// fbb_map_ram
// single write, single read map memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fbb_map_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [AW-1:0]                  waddr,
  input  wire logic [fbb_pkg::WORD_BITS-1:0]  wdata,
  input  wire logic [AW-1:0]                  raddr,
  output logic      [fbb_pkg::WORD_BITS-1:0]  rdata
);

  logic [fbb_pkg::WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fbb_word_eval.sv
// ----------------------------------------------------------------------------
// fbb_word_eval
// masks one map word to the valid range, finds its lowest clear bit and
// counts its clear bits
// ----------------------------------------------------------------------------
`default_nettype none

module fbb_word_eval (
  input  wire logic [fbb_pkg::WORD_BITS-1:0] word,
  input  wire logic [fbb_pkg::WIDX_W-1:0]    word_idx,
  input  wire logic [fbb_pkg::CNT_W-1:0]     eff,
  output fbb_pkg::word_eval_t                ev
);

  logic [fbb_pkg::WORD_BITS-1:0] mask;
  logic [fbb_pkg::WORD_BITS-1:0] clear_bits;
  logic [fbb_pkg::WIDX_W-1:0]    full_words;

  assign full_words = {1'b0, eff[fbb_pkg::CNT_W-1:fbb_pkg::POS_W]};

  always_comb begin
    if (word_idx < full_words) begin
      mask = '1;
    end else if (word_idx == full_words) begin
      mask = (fbb_pkg::WORD_BITS'(1) << eff[fbb_pkg::POS_W-1:0]) - fbb_pkg::WORD_BITS'(1);
    end else begin
      mask = '0;
    end
  end

  assign clear_bits = ~word & mask;

  // priority encode from the top so the lowest clear bit wins
  always_comb begin
    ev.has_zero = |clear_bits;
    ev.zero_pos = '0;
    ev.zero_cnt = '0;
    for (int i = fbb_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (clear_bits[i]) begin
        ev.zero_pos = fbb_pkg::POS_W'(i);
      end
    end
    for (int i = 0; i < fbb_pkg::WORD_BITS; i++) begin
      ev.zero_cnt = ev.zero_cnt + fbb_pkg::ZCNT_W'(clear_bits[i]);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/free_block_bitmap_unit.sv
// ----------------------------------------------------------------------------
// free_block_bitmap_unit
// block allocation map with running free count and first-free search
// ----------------------------------------------------------------------------
// The map is held as 32-bit words in one memory with registered read data. An
// item is taken when start is high and busy is low; busy then stays high
// until the result goes out. An in-range item reads its word, writes it back
// modified on the next cycle, and then the map is scanned one word per cycle
// from word 0 until a clear bit below the valid count turns up or the valid
// words run out. The result shows on the output ports for exactly one cycle
// with done high; there is no back-pressure, so capture it on that cycle. The
// valid count is the effective bit count (bits_in_use capped at MAP_BITS and
// at the 11-bit maximum); an out-of-range item skips the write step and goes
// straight to the scan. The scan is word-serial through the map memory's
// single read port. After reset a clearing pass writes zero to every word with
// busy high. A write to bits_in_use while idle with no item taken, on the last
// clearing cycle or during a recount starts a recount of the free counter over
// the new valid range with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module free_block_bitmap_unit #(
  parameter int MAP_BITS = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // item in
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 action,
  input  wire logic [fbb_pkg::IDX_W-1:0]  blk_index,
  // configuration
  input  wire logic                       cfg_wr_en,
  input  wire logic [fbb_pkg::CNT_W-1:0]  cfg_wr_data,
  // result out
  output logic                            done,
  output logic                            status,
  output logic                            bit_value,
  output logic [fbb_pkg::IDX_W-1:0]       first_free_index,
  output logic                            none_free,
  output logic [fbb_pkg::CNT_W-1:0]       free_total
);

  // map geometry
  localparam int NWORDS = (MAP_BITS + fbb_pkg::WORD_BITS - 1) / fbb_pkg::WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);
  // largest effective count the 11-bit register can express for this map
  localparam logic [fbb_pkg::CNT_W-1:0] MAP_CAP =
    fbb_pkg::CNT_W'((MAP_BITS > fbb_pkg::CNT_MAX) ? fbb_pkg::CNT_MAX : MAP_BITS);
  localparam logic [fbb_pkg::CNT_W-1:0] BITS_RESET = fbb_pkg::CNT_W'(1024);

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;  // zeroing the map after reset
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MODIFY = 3'd2;  // read data back, write word
  localparam logic [2:0] ST_SCAN   = 3'd3;  // first-free search
  localparam logic [2:0] ST_COUNT  = 3'd4;  // free recount after a count write

  logic [2:0]                  state;
  logic [fbb_pkg::CNT_W-1:0]   bits_in_use;
  logic [fbb_pkg::CNT_W-1:0]   free_counter;
  logic [fbb_pkg::CNT_W-1:0]   count_acc;
  logic [AW-1:0]               clr_addr;

  // latched item
  logic [1:0]                  action_r;
  logic [fbb_pkg::IDX_W-1:0]   idx_r;
  logic                        status_r;
  logic                        bit_value_r;

  // scan pipeline: issue counter and tag of the word whose data is back
  logic [fbb_pkg::WIDX_W-1:0]  rd_cnt;
  logic                        pend;
  logic [fbb_pkg::WIDX_W-1:0]  pend_tag;

  // memory port
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [fbb_pkg::WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [fbb_pkg::WORD_BITS-1:0] ram_rdata;

  logic [fbb_pkg::CNT_W-1:0]   eff;
  logic [fbb_pkg::CNT_W:0]     eff_round;
  logic [fbb_pkg::WIDX_W-1:0]  n_words;
  logic                        issue;
  logic                        accept;
  logic                        in_range;
  fbb_pkg::word_eval_t         ev;

  // modify path
  logic [fbb_pkg::POS_W-1:0]   bit_pos;
  logic                        old_bit;
  logic                        new_bit;
  logic [fbb_pkg::WORD_BITS-1:0] pos_mask;

  // effective count and the number of words it covers
  assign eff       = (bits_in_use > MAP_CAP) ? MAP_CAP : bits_in_use;
  assign eff_round = {1'b0, eff} + (fbb_pkg::CNT_W + 1)'(fbb_pkg::WORD_BITS - 1);
  assign n_words   = eff_round[fbb_pkg::CNT_W:fbb_pkg::POS_W];

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = ({1'b0, blk_index} < eff);
  assign issue    = (rd_cnt < n_words);

  // bit update of the word that came back
  assign bit_pos  = idx_r[fbb_pkg::POS_W-1:0];
  assign old_bit  = ram_rdata[bit_pos];
  assign pos_mask = fbb_pkg::WORD_BITS'(1) << bit_pos;

  always_comb begin
    case (action_r)
      fbb_pkg::ACT_USE:  new_bit = 1'b1;
      fbb_pkg::ACT_FREE: new_bit = 1'b0;
      default:           new_bit = old_bit;  // test, and the unused code
    endcase
  end

  // memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_raddr = AW'(rd_cnt);
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        // start the word read straight from the item port
        ram_raddr = AW'(blk_index[fbb_pkg::IDX_W-1:fbb_pkg::POS_W]);
      end
      ST_MODIFY: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_r[fbb_pkg::IDX_W-1:fbb_pkg::POS_W]);
        ram_wdata = new_bit ? (ram_rdata | pos_mask) : (ram_rdata & ~pos_mask);
      end
      ST_SCAN, ST_COUNT: begin
        ram_raddr = AW'(rd_cnt);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  fbb_map_ram #(
    .DEPTH (NWORDS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // evaluates the word that came back in the scan or the recount
  fbb_word_eval u_eval (
    .word     (ram_rdata),
    .word_idx (pend_tag),
    .eff      (eff),
    .ev       (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      bits_in_use <= BITS_RESET;
      clr_addr    <= '0;
      done        <= 1'b0;
      pend        <= 1'b0;
      rd_cnt      <= '0;
    end else begin
      done <= 1'b0;

      // register always written; idle with no item taken, a recount follows
      if (cfg_wr_en) begin
        bits_in_use <= cfg_wr_data;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_WORD) begin
            // every bit free: the count equals the valid range
            free_counter <= eff;
            state        <= ST_IDLE;
            if (cfg_wr_en) begin
              // count written on the last clearing cycle: recount the new range
              rd_cnt    <= '0;
              pend      <= 1'b0;
              count_acc <= '0;
              state     <= ST_COUNT;
            end
          end
        end

        ST_IDLE: begin
          if (accept) begin
            action_r    <= action;
            idx_r       <= blk_index;
            status_r    <= !in_range;
            bit_value_r <= 1'b0;
            rd_cnt      <= '0;
            pend        <= 1'b0;
            state       <= in_range ? ST_MODIFY : ST_SCAN;
          end else if (cfg_wr_en) begin
            rd_cnt    <= '0;
            pend      <= 1'b0;
            count_acc <= '0;
            state     <= ST_COUNT;
          end
        end

        ST_MODIFY: begin
          bit_value_r <= new_bit;
          if (old_bit && !new_bit) begin
            free_counter <= free_counter + fbb_pkg::CNT_W'(1);
          end else if (!old_bit && new_bit) begin
            free_counter <= free_counter - fbb_pkg::CNT_W'(1);
          end
          state <= ST_SCAN;
        end

        ST_SCAN: begin
          pend     <= issue;
          pend_tag <= rd_cnt;
          if (issue) begin
            rd_cnt <= rd_cnt + fbb_pkg::WIDX_W'(1);
          end
          if (pend && ev.has_zero) begin
            done             <= 1'b1;
            none_free        <= 1'b0;
            first_free_index <= fbb_pkg::IDX_W'({pend_tag, ev.zero_pos});
            state            <= ST_IDLE;
          end else if (!pend && !issue) begin
            done             <= 1'b1;
            none_free        <= 1'b1;
            first_free_index <= '0;
            state            <= ST_IDLE;
          end
          status     <= status_r;
          bit_value  <= bit_value_r;
          free_total <= free_counter;
        end

        ST_COUNT: begin
          if (cfg_wr_en) begin
            // count changed again: restart the recount
            rd_cnt    <= '0;
            pend      <= 1'b0;
            count_acc <= '0;
          end else begin
            pend     <= issue;
            pend_tag <= rd_cnt;
            if (issue) begin
              rd_cnt <= rd_cnt + fbb_pkg::WIDX_W'(1);
            end
            if (pend) begin
              count_acc <= count_acc + fbb_pkg::CNT_W'(ev.zero_cnt);
            end
            if (!pend && !issue) begin
              free_counter <= count_acc;
              state        <= ST_IDLE;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fbb_checker.sv
// ----------------------------------------------------------------------------
// fbb_checker
// port-level checks on the free block bitmap unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fbb_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       done,
  input wire logic                       status,
  input wire logic                       bit_value,
  input wire logic [fbb_pkg::IDX_W-1:0]  first_free_index,
  input wire logic                       none_free,
  input wire logic [fbb_pkg::CNT_W-1:0]  free_total
);

  // an accepted item keeps the unit busy on the next cycle
  `ASSERT_CLK(a_accept_busy, clk, rst, (start && !busy) |=> busy, "item taken but not busy")

  // a result only closes a busy period
  `ASSERT_CLK(a_done_after_busy, clk, rst, done |-> (!busy && $past(busy)), "stray result")

  // out-of-range items report a clear bit
  `ASSERT_CLK(a_oor_value, clk, rst, (done && status) |-> !bit_value, "bit set on range error")

  // nothing free gives index zero
  `ASSERT_CLK(a_none_index, clk, rst, (done && none_free) |-> (first_free_index == '0),
              "index not zero with none free")

  // a free bit found means the running count cannot be zero
  `ASSERT_CLK(a_count_found, clk, rst, (done && !none_free) |-> (free_total != '0),
              "free bit found but count zero")

endmodule

bind free_block_bitmap_unit fbb_checker u_fbb_checker (.*);

`default_nettype wire
